// ----- hw/rtl/sct_pkg.sv -----
package sct_pkg;

   localparam int TOKEN_SLOTS = 64;
   localparam int IdxW = 6;
   localparam int CntW = ($clog2(TOKEN_SLOTS) > IdxW) ? $clog2(TOKEN_SLOTS) : IdxW;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   typedef enum logic [2:0] {
      KIND_WORD = 3'd0,
      KIND_PIPE = 3'd1,
      KIND_OUT  = 3'd2,
      KIND_APP  = 3'd3,
      KIND_IN   = 3'd4,
      KIND_BG   = 3'd5,
      KIND_SEMI = 3'd6,
      KIND_END  = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type        kind;
      logic [7:0]      text_byte;
      logic            has_byte;
      logic            done;
      logic [IdxW-1:0] index;
      logic            last;
   } rsp_type;

   function automatic rsp_type make_rsp(kind_type kind, logic [7:0] text_byte,
                                        logic has_byte, logic done,
                                        logic [CntW-1:0] count);
      rsp_type r;
      r.kind      = kind;
      r.text_byte = has_byte ? text_byte : 8'h00;
      r.has_byte  = has_byte;
      r.done      = done;
      r.index     = count[IdxW-1:0];
      r.last      = 1'b0;
      return r;
   endfunction

   function automatic logic is_sep(logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB);
   endfunction

   function automatic logic is_single_op(logic [7:0] b);
      return (b == CH_PIPE) || (b == CH_LT) || (b == CH_AMP) || (b == CH_SEMI);
   endfunction

   function automatic kind_type single_op_kind(logic [7:0] b);
      kind_type k;
      case (b)
         CH_PIPE: k = KIND_PIPE;
         CH_LT:   k = KIND_IN;
         CH_AMP:  k = KIND_BG;
         CH_SEMI: k = KIND_SEMI;
         default: k = KIND_WORD;
      endcase
      return k;
   endfunction

endpackage

// ----- hw/rtl/shell_command_tokenizer_unit.sv -----
// Streaming command-line lexer. One byte enters per req transaction on
// req_char_code; a zero byte ends the line. Each byte yields zero, one or two
// rsp transactions (token kind, word byte, done flag, token index, and a flag
// on the last result that byte caused).
// Results of a byte are registered and presented in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
// and rsp_stall is low; a byte that yields two results holds the single-wide
// result port until both are taken. All lexing is one pass of compare logic
// from the mode, quote and token-count registers into a two-entry result buffer.
// req_stall rises while the result buffer cannot take a full byte's results:
// with two results waiting, or one waiting while rsp_stall is high.
// A stalled rsp transaction holds its payload until taken.
// After 63 tokens on a line, bytes are dropped until the zero byte.
// Reset (synchronous) returns the lexer to idle between tokens with a zero
// token count and empties the result buffer.
module shell_command_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_has_byte,
   output logic       rsp_token_done,
   output logic [5:0] rsp_token_index,
   output logic       rsp_last_in_step
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_QUOTE,
      MODE_GT,
      MODE_DROP
   } mode_type;

   localparam logic [sct_pkg::CntW-1:0] LimitCnt = sct_pkg::CntW'(sct_pkg::TOKEN_SLOTS - 1);
   localparam logic [sct_pkg::CntW-1:0] OneCnt   = sct_pkg::CntW'(1);

   mode_type                  mode_ff, mode_in;
   logic                      quote_dq_ff, quote_dq_in;
   logic [sct_pkg::CntW-1:0]  cnt_ff, cnt_in;

   sct_pkg::rsp_type          buf_ff [2];
   sct_pkg::rsp_type          buf_in [2];
   logic [1:0]                fill_ff, fill_in;

   sct_pkg::rsp_type          res [2];
   logic [1:0]                n_res;

   logic req_take, rsp_take;

   assign rsp_valid = (fill_ff != 2'd0);
   assign req_stall = (fill_ff == 2'd2) || ((fill_ff == 2'd1) && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Lexer step for the byte on the input port.
   always_comb begin
      logic [7:0] b;
      mode_type   eff_mode;
      logic       go_idle;
      logic       quote_hit;

      b        = req_char_code;
      mode_in  = mode_ff;
      quote_dq_in = quote_dq_ff;
      cnt_in   = cnt_ff;
      n_res    = 2'd0;
      go_idle  = 1'b0;
      res[0]   = '0;
      res[1]   = '0;

      eff_mode  = ((mode_ff == MODE_IDLE) && (cnt_ff >= LimitCnt)) ? MODE_DROP : mode_ff;
      quote_hit = quote_dq_ff ? (b == sct_pkg::CH_DQ) : (b == sct_pkg::CH_SQ);

      case (eff_mode)
         MODE_WORD, MODE_QUOTE: begin
            if (b == sct_pkg::CH_NUL) begin
               res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_WORD, 8'h00, 1'b0, 1'b1,
                                                 cnt_in);
               n_res  = n_res + 2'd1;
               cnt_in = cnt_in + OneCnt;
            end else if ((eff_mode == MODE_WORD) ? (sct_pkg::is_sep(b) ||
                         (b == sct_pkg::CH_GT) || sct_pkg::is_single_op(b)) : quote_hit) begin
               res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_WORD, 8'h00, 1'b0, 1'b1,
                                                 cnt_in);
               n_res   = n_res + 2'd1;
               cnt_in  = cnt_in + OneCnt;
               mode_in = (cnt_in >= LimitCnt) ? MODE_DROP : MODE_IDLE;
               // a closing quote is consumed; a word delimiter is then handled as a byte between tokens
               go_idle = (eff_mode == MODE_WORD) && (cnt_in < LimitCnt);
            end else begin
               res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_WORD, b, 1'b1, 1'b0, cnt_in);
               n_res = n_res + 2'd1;
            end
         end
         MODE_GT: begin
            if (b == sct_pkg::CH_GT) begin
               res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_APP, 8'h00, 1'b0, 1'b1,
                                                 cnt_in);
               n_res   = n_res + 2'd1;
               cnt_in  = cnt_in + OneCnt;
               mode_in = (cnt_in >= LimitCnt) ? MODE_DROP : MODE_IDLE;
            end else begin
               res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_OUT, 8'h00, 1'b0, 1'b1,
                                                 cnt_in);
               n_res  = n_res + 2'd1;
               cnt_in = cnt_in + OneCnt;
               if (b != sct_pkg::CH_NUL) begin
                  mode_in = (cnt_in >= LimitCnt) ? MODE_DROP : MODE_IDLE;
                  go_idle = (cnt_in < LimitCnt);
               end
            end
         end
         MODE_DROP: begin
            mode_in = MODE_DROP;
         end
         default: begin
            mode_in = MODE_IDLE;
            go_idle = (b != sct_pkg::CH_NUL);
         end
      endcase

      // byte arriving between tokens
      if (go_idle) begin
         if (sct_pkg::is_sep(b)) begin
            mode_in = MODE_IDLE;
         end else if (b == sct_pkg::CH_GT) begin
            mode_in = MODE_GT;
         end else if (sct_pkg::is_single_op(b)) begin
            res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::single_op_kind(b), 8'h00, 1'b0, 1'b1,
                                              cnt_in);
            n_res   = n_res + 2'd1;
            cnt_in  = cnt_in + OneCnt;
            mode_in = (cnt_in >= LimitCnt) ? MODE_DROP : MODE_IDLE;
         end else if ((b == sct_pkg::CH_DQ) || (b == sct_pkg::CH_SQ)) begin
            mode_in     = MODE_QUOTE;
            quote_dq_in = (b == sct_pkg::CH_DQ);
         end else begin
            mode_in = MODE_WORD;
            res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_WORD, b, 1'b1, 1'b0, cnt_in);
            n_res = n_res + 2'd1;
         end
      end

      if (b == sct_pkg::CH_NUL) begin
         res[n_res[0]] = sct_pkg::make_rsp(sct_pkg::KIND_END, 8'h00, 1'b0, 1'b1, cnt_in);
         n_res       = n_res + 2'd1;
         mode_in     = MODE_IDLE;
         quote_dq_in = 1'b0;
         cnt_in      = '0;
      end

      if (n_res == 2'd1) begin
         res[0].last = 1'b1;
      end
      if (n_res == 2'd2) begin
         res[1].last = 1'b1;
      end
   end

   // Result buffer: a new byte is taken only when the buffer drains this cycle.
   always_comb begin
      buf_in[0] = buf_ff[0];
      buf_in[1] = buf_ff[1];
      fill_in   = fill_ff;
      if (req_take) begin
         buf_in[0] = res[0];
         buf_in[1] = res[1];
         fill_in   = n_res;
      end else if (rsp_take) begin
         buf_in[0] = buf_ff[1];
         fill_in   = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff[0] <= buf_in[0];
      buf_ff[1] <= buf_in[1];
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         quote_dq_ff <= 1'b0;
         cnt_ff      <= '0;
         fill_ff     <= 2'd0;
      end else begin
         if (req_take) begin
            mode_ff     <= mode_in;
            quote_dq_ff <= quote_dq_in;
            cnt_ff      <= cnt_in;
         end
         fill_ff <= fill_in;
      end
   end

   assign rsp_token_kind   = buf_ff[0].kind;
   assign rsp_text_byte    = buf_ff[0].text_byte;
   assign rsp_has_byte     = buf_ff[0].has_byte;
   assign rsp_token_done   = buf_ff[0].done;
   assign rsp_token_index  = buf_ff[0].index;
   assign rsp_last_in_step = buf_ff[0].last;

endmodule
